FILE: hw/rtl/assert_macros.svh
// Assertion macros used by the top-level RTL file of the radix-to-ASCII converter.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check on every rising clk edge, held off while rst_n is low.
`define URTA_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error(msg);

// Check on every rising clk edge, reset cycles included.
`define URTA_ASSERT_RST(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: hw/rtl/urta_pkg.sv
// Types, codes and character tables of the radix-to-ASCII converter.
package urta_pkg;

  typedef struct packed {
    logic [63:0] value;
    logic [1:0]  func;
    logic        alternate_form;
    logic [1:0]  size_mode;
  } in_item_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       last;
  } out_item_t;

  localparam logic [1:0] FUNC_DEC    = 2'd0;
  localparam logic [1:0] FUNC_OCT    = 2'd1;
  localparam logic [1:0] FUNC_HEX_LO = 2'd2;
  localparam logic [1:0] FUNC_HEX_UP = 2'd3;

  localparam logic [1:0] SIZE_32 = 2'd0;
  localparam logic [1:0] SIZE_64 = 2'd1;
  localparam logic [1:0] SIZE_16 = 2'd2;

  // Classified conversion job handed from the front to the back.
  typedef struct packed {
    logic [63:0] num;
    logic [1:0]  func;
    logic        prefix;
    logic [1:0]  size;
  } job_t;

  typedef struct packed {
    logic busy;
    logic emit;
    logic last;
  } back_stat_t;

  localparam logic [7:0] CH_ZERO = 8'h30;
  localparam logic [7:0] CH_X_LO = 8'h78;
  localparam logic [7:0] CH_X_UP = 8'h58;

  localparam logic [7:0] DIGITS_LO [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };
  localparam logic [7:0] DIGITS_UP [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
  };

endpackage

FILE: hw/rtl/urta_front.sv
// Front end: truncate the value and classify radix, size and prefix.
module urta_front (
  input  urta_pkg::in_item_t in_data,
  output urta_pkg::job_t     job
);

  logic [1:0] size;

  always_comb begin
    case (in_data.size_mode)
      urta_pkg::SIZE_64: size = urta_pkg::SIZE_64;
      urta_pkg::SIZE_16: size = urta_pkg::SIZE_16;
      default:           size = urta_pkg::SIZE_32;
    endcase
  end

  always_comb begin
    job.func   = in_data.func;
    job.size   = size;
    // prefix looks at the value before truncation
    job.prefix = in_data.alternate_form && (in_data.value != 64'd0) &&
                 (in_data.func != urta_pkg::FUNC_DEC);
    case (size)
      urta_pkg::SIZE_64: job.num = in_data.value;
      urta_pkg::SIZE_16: job.num = {48'd0, in_data.value[15:0]};
      default:           job.num = {32'd0, in_data.value[31:0]};
    endcase
  end

endmodule

FILE: hw/rtl/urta_fifo.sv
// Small register queue between the front and the back.
module urta_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

FILE: hw/rtl/urta_back.sv
// Back end: build the digit string and emit it one character per cycle while the result is not stalled.
module urta_back (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  job_valid,
  input  urta_pkg::job_t        job,
  output logic                  job_pop,
  input  logic                  pop,
  output logic                  empty,
  output urta_pkg::out_item_t   out_data,
  output urta_pkg::back_stat_t  stat
);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_CONV = 6'b000010,
    ST_SKIP = 6'b000100,
    ST_PRE0 = 6'b001000,
    ST_PREX = 6'b010000,
    ST_DIG  = 6'b100000
  } state_t;

  // Four binary bits into a 20-digit BCD word, shift-add-3 per bit.
  function automatic logic [79:0] dabble4(input logic [79:0] bcd, input logic [3:0] bits);
    logic [79:0] b;
    b = bcd;
    for (int s = 3; s >= 0; s--) begin
      for (int d = 0; d < 20; d++) begin
        if (b[4*d +: 4] >= 4'd5) begin
          b[4*d +: 4] = b[4*d +: 4] + 4'd3;
        end
      end
      b = {b[78:0], bits[s]};
    end
    return b;
  endfunction

  // Spread octal digits into 4-bit slots.
  function automatic logic [87:0] oct_spread(input logic [63:0] v);
    logic [65:0] vp;
    logic [87:0] o;
    vp = {2'b00, v};
    for (int i = 0; i < 22; i++) begin
      o[4*i +: 4] = {1'b0, vp[3*i +: 3]};
    end
    return o;
  endfunction

  state_t          state_r, state_nxt;
  logic [87:0]     dig_r, dig_nxt;
  logic [63:0]     sh_r, sh_nxt;
  logic [4:0]      cnt_r, cnt_nxt;
  logic            upper_r, upper_nxt;
  logic            hex_r, hex_nxt;
  logic            prefix_r, prefix_nxt;
  logic [1:0]      size_r, size_nxt;
  logic            out_valid_r, out_valid_nxt;
  urta_pkg::out_item_t out_data_r, out_data_nxt;

  logic            out_ok;
  logic            emit;
  logic [7:0]      emit_char;
  logic            emit_last;
  logic [3:0]      top;
  logic [79:0]     step;
  logic [87:0]     spread;

  assign out_ok = !out_valid_r || pop;
  assign top    = dig_r[87:84];
  assign step   = dabble4(dig_r[79:0], sh_r[63:60]);
  assign spread = oct_spread(job.num);

  always_comb begin
    state_nxt  = state_r;
    dig_nxt    = dig_r;
    sh_nxt     = sh_r;
    cnt_nxt    = cnt_r;
    upper_nxt  = upper_r;
    hex_nxt    = hex_r;
    prefix_nxt = prefix_r;
    size_nxt   = size_r;
    job_pop    = 1'b0;
    emit       = 1'b0;
    emit_char  = urta_pkg::CH_ZERO;
    emit_last  = 1'b0;

    case (state_r)
      ST_IDLE: begin
        if (job_valid) begin
          job_pop    = 1'b1;
          upper_nxt  = (job.func == urta_pkg::FUNC_HEX_UP);
          hex_nxt    = (job.func == urta_pkg::FUNC_HEX_LO) ||
                       (job.func == urta_pkg::FUNC_HEX_UP);
          prefix_nxt = job.prefix;
          size_nxt   = job.size;
          case (job.func)
            urta_pkg::FUNC_DEC: begin
              state_nxt = ST_CONV;
              dig_nxt   = '0;
              case (job.size)
                urta_pkg::SIZE_16: begin
                  sh_nxt  = {job.num[15:0], 48'd0};
                  cnt_nxt = 5'd4;
                end
                urta_pkg::SIZE_64: begin
                  sh_nxt  = job.num;
                  cnt_nxt = 5'd16;
                end
                default: begin
                  sh_nxt  = {job.num[31:0], 32'd0};
                  cnt_nxt = 5'd8;
                end
              endcase
            end
            urta_pkg::FUNC_OCT: begin
              state_nxt = ST_SKIP;
              case (job.size)
                urta_pkg::SIZE_16: begin
                  dig_nxt = {spread[23:0], 64'd0};
                  cnt_nxt = 5'd6;
                end
                urta_pkg::SIZE_64: begin
                  dig_nxt = spread;
                  cnt_nxt = 5'd22;
                end
                default: begin
                  dig_nxt = {spread[43:0], 44'd0};
                  cnt_nxt = 5'd11;
                end
              endcase
            end
            default: begin
              state_nxt = ST_SKIP;
              case (job.size)
                urta_pkg::SIZE_16: begin
                  dig_nxt = {job.num[15:0], 72'd0};
                  cnt_nxt = 5'd4;
                end
                urta_pkg::SIZE_64: begin
                  dig_nxt = {job.num, 24'd0};
                  cnt_nxt = 5'd16;
                end
                default: begin
                  dig_nxt = {job.num[31:0], 56'd0};
                  cnt_nxt = 5'd8;
                end
              endcase
            end
          endcase
        end
      end

      ST_CONV: begin
        sh_nxt = {sh_r[59:0], 4'd0};
        if (cnt_r == 5'd1) begin
          // align the BCD result to the top and load the digit count
          state_nxt = ST_SKIP;
          case (size_r)
            urta_pkg::SIZE_16: begin
              dig_nxt = {step[19:0], 68'd0};
              cnt_nxt = 5'd5;
            end
            urta_pkg::SIZE_64: begin
              dig_nxt = {step, 8'd0};
              cnt_nxt = 5'd20;
            end
            default: begin
              dig_nxt = {step[39:0], 48'd0};
              cnt_nxt = 5'd10;
            end
          endcase
        end else begin
          dig_nxt = {8'd0, step};
          cnt_nxt = cnt_r - 5'd1;
        end
      end

      ST_SKIP: begin
        // drop leading zeros, keep at least one digit
        if ((top == 4'd0) && (cnt_r > 5'd1)) begin
          dig_nxt = {dig_r[83:0], 4'd0};
          cnt_nxt = cnt_r - 5'd1;
        end else begin
          state_nxt = prefix_r ? ST_PRE0 : ST_DIG;
        end
      end

      ST_PRE0: begin
        if (out_ok) begin
          emit      = 1'b1;
          emit_char = urta_pkg::CH_ZERO;
          state_nxt = hex_r ? ST_PREX : ST_DIG;
        end
      end

      ST_PREX: begin
        if (out_ok) begin
          emit      = 1'b1;
          emit_char = upper_r ? urta_pkg::CH_X_UP : urta_pkg::CH_X_LO;
          state_nxt = ST_DIG;
        end
      end

      ST_DIG: begin
        if (out_ok) begin
          emit      = 1'b1;
          emit_char = upper_r ? urta_pkg::DIGITS_UP[top] : urta_pkg::DIGITS_LO[top];
          emit_last = (cnt_r == 5'd1);
          dig_nxt   = {dig_r[83:0], 4'd0};
          cnt_nxt   = cnt_r - 5'd1;
          if (cnt_r == 5'd1) begin
            state_nxt = ST_IDLE;
          end
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (emit) begin
      out_valid_nxt          = 1'b1;
      out_data_nxt.char_code = emit_char;
      out_data_nxt.last      = emit_last;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dig_r      <= dig_nxt;
    sh_r       <= sh_nxt;
    cnt_r      <= cnt_nxt;
    upper_r    <= upper_nxt;
    hex_r      <= hex_nxt;
    prefix_r   <= prefix_nxt;
    size_r     <= size_nxt;
    out_data_r <= out_data_nxt;
  end

  assign empty     = !out_valid_r;
  assign out_data  = out_data_r;
  assign stat.busy = (state_r != ST_IDLE);
  assign stat.emit = emit;
  assign stat.last = emit_last;

endmodule

FILE: hw/rtl/unsigned_radix_to_ascii_top.sv
// Top level of the unsigned radix-to-ASCII converter.
//
//   channel   handshake           payload                         transaction
//   input     push / full         value, func, alt form, size     one number
//   result    empty / pop         char_code, last                 one character
//
// The front truncates and classifies each number and queues it (QDEPTH jobs),
// so new numbers are taken while the back is still printing an earlier one.
// Per number the back loads the job, runs 4-bit shift-add-3 steps over the
// 16, 32 or 64 value bits for decimal only, drops leading zero digits while
// keeping at least one, then emits the prefix, if any, and the digits.
// Reset (rst_n low, synchronous) empties the queue and the result register.
// A stalled result holds in its register and stalls only the back end.
`include "assert_macros.svh"

module unsigned_radix_to_ascii_top #(
  parameter int QDEPTH = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  urta_pkg::in_item_t   in_data,
  input  logic                 pop,
  output logic                 empty,
  output urta_pkg::out_item_t  out_data
);

  urta_pkg::job_t       front_job;
  urta_pkg::job_t       q_job;
  logic                 q_empty;
  logic                 q_pop;
  urta_pkg::back_stat_t back_stat;

  // Classify the incoming number; push goes straight into the queue.
  urta_front u_front (
    .in_data (in_data),
    .job     (front_job)
  );

  // Decouple front and back; full backs up onto the input channel.
  urta_fifo #(
    .WIDTH ($bits(urta_pkg::job_t)),
    .DEPTH (QDEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .wdata (front_job),
    .full  (full),
    .pop   (q_pop),
    .rdata (q_job),
    .empty (q_empty)
  );

  // Convert and emit characters through the result register.
  urta_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (!q_empty),
    .job       (q_job),
    .job_pop   (q_pop),
    .pop       (pop),
    .empty     (empty),
    .out_data  (out_data),
    .stat      (back_stat)
  );

  // A transaction into an empty queue must show up in the queue in the next cycle.
  `URTA_ASSERT(a_queue_fill, (push && !full && q_empty) |=> !q_empty, "queued job lost")
  // The last character of a number returns the back end to idle.
  `URTA_ASSERT(a_last_idle, (back_stat.emit && back_stat.last) |=> !back_stat.busy,
               "back end busy after last character")
  // A popped result with nothing new behind it leaves the register empty.
  `URTA_ASSERT(a_pop_drain, (pop && !empty && !back_stat.emit) |=> empty,
               "result register not drained")
  // Reset clears the result register.
  `URTA_ASSERT_RST(a_reset_empty, !rst_n |=> empty, "result pending after reset")

endmodule
